// ===== design/lattice_value_noise_3d_top_defines.svh =====
// assertion macros shared by the checker
`ifndef LATTICE_VALUE_NOISE_3D_TOP_DEFINES_SVH
`define LATTICE_VALUE_NOISE_3D_TOP_DEFINES_SVH

// clocked assertion, off while reset is held
`define LVN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion, checked during reset as well
`define LVN_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/lvn_pkg.sv =====
`default_nettype none
package lvn_pkg;
    localparam logic [2:0] OP_EVAL    = 3'd0;
    localparam logic [2:0] OP_WR_XPERM = 3'd1;
    localparam logic [2:0] OP_WR_YPERM = 3'd2;
    localparam logic [2:0] OP_WR_ZPERM = 3'd3;
    localparam logic [2:0] OP_WR_VALUE = 3'd4;

    localparam int COORD_W = 32;
    localparam int INDEX_W = 8;
    localparam int DATA_W  = 16;
    localparam int NOISE_W = 16;
    localparam logic [NOISE_W-1:0] NOISE_MAX = '1;
endpackage
`default_nettype wire

// ===== design/lvn_if.sv =====
`default_nettype none
interface lvn_req_if import lvn_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [2:0]                opcode;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
    logic [INDEX_W-1:0]        entry_index;
    logic [DATA_W-1:0]         entry_data;

    modport source (output valid, opcode, x_coord, y_coord, z_coord, entry_index,
                    entry_data, input ready);
    modport sink   (input valid, opcode, x_coord, y_coord, z_coord, entry_index,
                    entry_data, output ready);
endinterface

interface lvn_rsp_if import lvn_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [NOISE_W-1:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface
`default_nettype wire

// ===== design/lattice_value_noise_3d_top.sv =====
`default_nettype none
// channel | dir | payload
// i_req   | in  | opcode, x_coord, y_coord, z_coord, entry_index, entry_data
// o_rsp   | out | noise_value (one per evaluate request)
//
// one request per cycle unless a stalled output holds ready low
// the pipeline runs through the table memories: cell reads, then corner reads,
// with two multiply steps for the smoothing alongside them, then two per blend level
// a stalled output freezes the whole pipeline, memories included
// reset clears only the valid bits; table contents are undefined until written
module lattice_value_noise_3d_top import lvn_pkg::*; #(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lvn_req_if.sink   i_req,
    lvn_rsp_if.source o_rsp
);
    localparam int IW = $clog2(TABLE_SIZE);
    localparam int F  = FRAC_BITS;
    localparam int SW = F + 1;
    localparam int PW = NOISE_W + SW;
    localparam logic [F+1:0] THREE_ONE = (F + 2)'(3) << F;
    localparam logic [SW-1:0] ONE      = SW'(1) << F;

    logic en;
    logic r_ovalid;
    logic [NOISE_W-1:0] r_noise;
    logic [7:0] r_vld;

    assign en          = !r_ovalid || o_rsp.ready;
    assign i_req.ready = en;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.noise_value = r_noise;

    logic acc;
    assign acc = i_req.valid && en;

    // write ports
    logic [IW-1:0] waddr;
    assign waddr = IW'(i_req.entry_index);

    // cell indices
    logic signed [COORD_W-1:0] coord [3];
    logic [IW-1:0] cell0 [3];
    logic [IW-1:0] cell1 [3];
    logic [IW-1:0] perm0 [3];
    logic [IW-1:0] perm1 [3];
    logic [2:0] perm_we;

    assign coord[0] = i_req.x_coord;
    assign coord[1] = i_req.y_coord;
    assign coord[2] = i_req.z_coord;
    assign perm_we[0] = acc && i_req.opcode == OP_WR_XPERM;
    assign perm_we[1] = acc && i_req.opcode == OP_WR_YPERM;
    assign perm_we[2] = acc && i_req.opcode == OP_WR_ZPERM;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [COORD_W-1:0] sh;
        assign sh       = coord[a] >>> F;
        assign cell0[a] = sh[IW-1:0];
        assign cell1[a] = cell0[a] + IW'(1);

        lvn_ram #(.WIDTH(IW), .DEPTH(TABLE_SIZE)) u_perm (
            .i_clk    (i_clk),
            .i_we     (perm_we[a]),
            .i_waddr  (waddr),
            .i_wdata  (i_req.entry_data[IW-1:0]),
            .i_re     (en),
            .i_raddr_a(cell0[a]),
            .i_raddr_b(cell1[a]),
            .o_rdata_a(perm0[a]),
            .o_rdata_b(perm1[a])
        );
    end

    // corner values, four copies for eight reads a cycle
    logic val_we;
    logic [NOISE_W-1:0] cval [8];
    assign val_we = acc && i_req.opcode == OP_WR_VALUE;

    for (genvar k = 0; k < 4; k++) begin : g_corner
        logic [IW-1:0] pxy;
        logic [IW-1:0] h0;
        logic [IW-1:0] h1;
        assign pxy = ((k >> 1) != 0 ? perm1[0] : perm0[0]) ^
                     ((k & 1) != 0 ? perm1[1] : perm0[1]);
        assign h0  = pxy ^ perm0[2];
        assign h1  = pxy ^ perm1[2];

        lvn_ram #(.WIDTH(NOISE_W), .DEPTH(TABLE_SIZE)) u_val (
            .i_clk    (i_clk),
            .i_we     (val_we),
            .i_waddr  (waddr),
            .i_wdata  (i_req.entry_data),
            .i_re     (en),
            .i_raddr_a(h0),
            .i_raddr_b(h1),
            .o_rdata_a(cval[2*k]),
            .o_rdata_b(cval[2*k+1])
        );
    end

    // smoothing s = u*u*(3-2u)
    logic [F-1:0]   r_u   [3];
    logic [F-1:0]   r_u1  [3];
    logic [2*F-1:0] r_uu  [3];
    logic [2*F+1:0] r_u2t [3];
    logic [SW-1:0]  s     [3];

    for (genvar a = 0; a < 3; a++) begin : g_smooth
        assign s[a] = r_u2t[a][2*F:F];
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_u[a]   <= coord[a][F-1:0];
                r_u1[a]  <= r_u[a];
                r_uu[a]  <= r_u[a] * r_u[a];
                r_u2t[a] <= r_uu[a][2*F-1:F] * (THREE_ONE - {r_u1[a], 1'b0});
            end
        end
    end

    // trilinear blend: z, y, x
    logic [NOISE_W-1:0] r_c  [8];
    logic [PW-1:0]      r_pz [8];
    logic [NOISE_W-1:0] r_e  [4];
    logic [PW-1:0]      r_py [4];
    logic [NOISE_W-1:0] r_f  [2];
    logic [PW-1:0]      r_px [2];
    logic [SW-1:0] r_sy_a, r_sy_b, r_sx_a, r_sx_b, r_sx_c, r_sx_d;
    logic [PW:0]   sum_x;
    logic [PW-F:0] res;

    assign sum_x = {1'b0, r_px[0]} + {1'b0, r_px[1]};
    assign res   = sum_x[PW:F];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c    <= cval;
            r_sy_a <= s[1];
            r_sx_a <= s[0];
            r_sy_b <= r_sy_a;
            r_sx_b <= r_sx_a;
            r_sx_c <= r_sx_b;
            r_sx_d <= r_sx_c;
            for (int i = 0; i < 4; i++) begin
                r_pz[2*i]   <= PW'(r_c[2*i] * (ONE - s[2]));
                r_pz[2*i+1] <= PW'(r_c[2*i+1] * s[2]);
                r_e[i]      <= NOISE_W'(({1'b0, r_pz[2*i]} + {1'b0, r_pz[2*i+1]}) >> F);
            end
            for (int i = 0; i < 2; i++) begin
                r_py[2*i]   <= PW'(r_e[2*i] * (ONE - r_sy_b));
                r_py[2*i+1] <= PW'(r_e[2*i+1] * r_sy_b);
                r_f[i]      <= NOISE_W'(({1'b0, r_py[2*i]} + {1'b0, r_py[2*i+1]}) >> F);
                r_px[i]     <= PW'(r_f[i] * (i == 0 ? ONE - r_sx_d : r_sx_d));
            end
            if (r_vld[7]) begin
                r_noise <= (res > (PW - F + 1)'(NOISE_MAX)) ? NOISE_MAX : NOISE_W'(res);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_vld    <= {r_vld[6:0], acc && i_req.opcode == OP_EVAL};
            r_ovalid <= r_vld[7];
        end
    end
endmodule
`default_nettype wire

// ===== design/lvn_ram.sv =====
`default_nettype none
module lvn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end
endmodule
`default_nettype wire

// ===== design/lvn_checker.sv =====
`default_nettype none
`include "lattice_value_noise_3d_top_defines.svh"
module lvn_checker import lvn_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_req_valid,
    input wire logic               i_req_ready,
    input wire logic               i_rsp_valid,
    input wire logic               i_rsp_ready,
    input wire logic [NOISE_W-1:0] i_rsp_noise
);
    `LVN_ASSERT(a_rsp_hold, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid, "result dropped")
    `LVN_ASSERT(a_rsp_stable, i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_noise), "result changed in stall")
    `LVN_ASSERT_ALWAYS(a_idle_ready, !i_rsp_valid |-> i_req_ready, "not ready with empty output")
    `LVN_ASSERT_ALWAYS(a_flow_ready, i_rsp_ready |-> i_req_ready, "not ready while output drains")
endmodule

bind lattice_value_noise_3d_top lvn_checker u_lvn_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_req_valid(i_req.valid),
    .i_req_ready(i_req.ready),
    .i_rsp_valid(o_rsp.valid),
    .i_rsp_ready(o_rsp.ready),
    .i_rsp_noise(o_rsp.noise_value)
);
`default_nettype wire
